@@ design/mcpi_pkg.sv @@
// Shared constants, codes and types for the motor current PI controller.
`timescale 1ns / 1ps

package mcpi_pkg;

   // Default build values
   localparam int MCPI_TEST_LENGTH = 100;
   localparam int MCPI_PWM_PERIOD  = 4000;

   // Register indexes on the csr port
   localparam logic [2:0] REG_MODE        = 3'd0;
   localparam logic [2:0] REG_PWM_COMMAND = 3'd1;
   localparam logic [2:0] REG_PROP_GAIN   = 3'd2;
   localparam logic [2:0] REG_INTEG_GAIN  = 3'd3;
   localparam logic [2:0] REG_INTEG_LIMIT = 3'd4;

   // Operating modes
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_PWM   = 3'd1;
   localparam logic [2:0] MODE_TEST  = 3'd2;
   localparam logic [2:0] MODE_HOLD  = 3'd3;
   localparam logic [2:0] MODE_TRACK = 3'd4;

   // How the result stage forms duty and direction
   localparam logic [1:0] KIND_ZERO = 2'd0; // idle: zero drive
   localparam logic [1:0] KIND_HOLD = 2'd1; // keep last duty and direction
   localparam logic [1:0] KIND_PWM  = 2'd2; // open-loop duty
   localparam logic [1:0] KIND_PI   = 2'd3; // closed-loop duty

   // Field widths
   localparam int CUR_W   = 16;
   localparam int ERR_W   = CUR_W + 1;
   localparam int INT_W   = 25;
   localparam int ACC_W   = INT_W + 1;
   localparam int GAIN_W  = 16;
   localparam int LIM_W   = 24;
   localparam int PPROP_W = 2 * ERR_W;
   localparam int PINT_W  = ERR_W + INT_W;
   localparam int U_W     = PINT_W + 1;
   localparam int DUTY_W  = 12;
   localparam int REF_W   = 9;
   localparam int IDX_W   = 7;
   localparam int CMD_W   = 8;
   localparam int CMAG_W  = 7;

   // PI output full scale: 100 percent in Q.12
   localparam int FULL_SCALE_Q12 = 409600;
   localparam int Q12_SHIFT      = 12;
   localparam int MAG_W          = 19;   // holds FULL_SCALE_Q12
   localparam int PERIOD_W       = 16;   // PWM_PERIOD up to 65535
   localparam int PROD_W         = MAG_W + PERIOD_W;
   localparam int NUM_W          = 23;   // dividend of the divide by 100

   // Divide by 100 as multiply by reciprocal: exact for NUM_W-bit dividends
   localparam int DIV_SHIFT = NUM_W + 7;
   localparam int RECIP_W   = 24;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100);
   localparam int QP_W = NUM_W + RECIP_W;
   localparam int QV_W = QP_W - DIV_SHIFT;

   localparam logic [CMAG_W-1:0]       CMD_MAX   = CMAG_W'(100);
   localparam logic signed [REF_W-1:0] TEST_AMPL = REF_W'(200);
   localparam logic [DUTY_W-1:0]       DUTY_MAX  = {DUTY_W{1'b1}};

   // Sideband that travels down the pipeline with each beat
   typedef struct packed {
      logic [1:0]              kind;
      logic                    dir;
      logic                    keep_dir;
      logic signed [REF_W-1:0] tref;
      logic [IDX_W-1:0]        tidx;
      logic                    tact;
   } meta_type;

endpackage

@@ design/motor_current_pi_controller_top.sv @@
// Motor current PI controller with anti-windup, open-loop PWM and self-test modes.
`timescale 1ns / 1ps

// Pipeline: six register stages, the first at the input, carry a request beat to its
//   response beat in rsp_tdata.
// Throughput: one beat per cycle while rsp_tready is high; the two multiplier stages and
//   the reciprocal divide-by-100 stage are fully pipelined. Stages collapse bubbles on stall.
// Reset: synchronous, active high; clears valids, mode, integrator, test state
//   and held duty/direction, and loads the gain and limit registers' defaults.
module motor_current_pi_controller_top #(
   parameter int TEST_LENGTH = mcpi_pkg::MCPI_TEST_LENGTH,
   parameter int PWM_PERIOD  = mcpi_pkg::MCPI_PWM_PERIOD
) (
   input  logic        clock,
   input  logic        reset,
   // request: [15:0] measured_current, [31:16] desired_current
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // response: [11:0] duty_count, [12] direction, [21:13] test_reference,
   //           [28:22] test_index, [29] test_active, [31:30] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import mcpi_pkg::*;

   localparam int CNT_W = $clog2(TEST_LENGTH);
   localparam int QW    = CNT_W + 2;   // 4 * counter, compared to quarter bounds
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TEST_LENGTH - 1);
   localparam logic [QW-1:0] Q1_BOUND = QW'(TEST_LENGTH);
   localparam logic [QW-1:0] Q2_BOUND = QW'(2 * TEST_LENGTH);
   localparam logic [QW-1:0] Q3_BOUND = QW'(3 * TEST_LENGTH);
   localparam logic [PERIOD_W-1:0] PERIOD_PWM = PERIOD_W'(PWM_PERIOD);
   localparam logic [PERIOD_W-1:0] PERIOD_PI  = PERIOD_W'(PWM_PERIOD - 1);

   // ---------------- configuration registers ----------------
   logic [2:0]        mode_ff;
   logic [CMD_W-1:0]  pwm_command_ff;
   logic [GAIN_W-1:0] prop_gain_ff;
   logic [GAIN_W-1:0] integ_gain_ff;
   logic [LIM_W-1:0]  integ_limit_ff;

   // ---------------- loop state ----------------
   logic signed [INT_W-1:0] integrator_ff, integrator_in;
   logic [CNT_W-1:0]        test_counter_ff, test_counter_in;
   logic signed [REF_W-1:0] test_level_ff, test_level_in;
   logic [DUTY_W-1:0]       duty_held_ff;
   logic                    dir_held_ff;
   logic                    test_done;   // last tick of a test run

   // ---------------- pipeline ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
   logic req_take;

   meta_type meta1_ff, meta1_in, meta2_ff, meta3_ff, meta3_in, meta4_ff, meta5_ff;
   logic [CMAG_W-1:0]        cmag1_ff, cmag1_in, cmag2_ff;
   logic signed [ERR_W-1:0]  err1_ff, err1_in;
   logic signed [INT_W-1:0]  acc1_ff;
   logic signed [PPROP_W-1:0] pprop2_ff, pprop2_in;
   logic signed [PINT_W-1:0]  pint2_ff, pint2_in;
   logic [MAG_W-1:0]         mag3_ff, mag3_in;
   logic [PROD_W-1:0]        prod4_ff, prod4_in;
   logic [QP_W-1:0]          qp5_ff, qp5_in;
   logic [DUTY_W-1:0]        duty_out_ff, duty_out_in;
   logic                     dir_out_ff, dir_out_in;
   meta_type                 meta_out_ff;

   // Bubble-collapsing ready chain: a stage loads when empty or draining.
   assign rdy6 = !rsp_valid_ff || rsp_tready;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign req_take   = req_tvalid && rdy1;

   // ---------------- stage 1: mode decode, error and integrator ----------------
   logic signed [CUR_W-1:0] meas, want, pi_ref;
   logic signed [ACC_W-1:0] acc_raw, lim_pos;
   logic signed [INT_W-1:0] acc_sat;
   logic [CMD_W-1:0]        cmd_abs;
   logic [QW-1:0]           quad;
   logic                    pi_run, last_tick;

   always_comb begin
      meas = $signed(req_tdata[CUR_W-1:0]);
      want = $signed(req_tdata[2*CUR_W-1:CUR_W]);
      meta1_in        = '0;
      meta1_in.kind   = KIND_ZERO;
      cmag1_in        = '0;
      pi_run          = 1'b0;
      pi_ref          = want;
      test_counter_in = test_counter_ff;
      test_level_in   = test_level_ff;
      test_done       = 1'b0;
      last_tick       = (test_counter_ff >= CNT_LAST);
      quad            = {test_counter_ff, 2'b00};
      cmd_abs = pwm_command_ff[CMD_W-1] ? CMD_W'(-pwm_command_ff) : pwm_command_ff;

      case (mode_ff)
         MODE_IDLE: begin
            meta1_in.kind = KIND_ZERO;
         end
         MODE_PWM: begin
            if (pwm_command_ff == '0) begin
               meta1_in.kind = KIND_HOLD;
            end else begin
               meta1_in.kind = KIND_PWM;
               meta1_in.dir  = !pwm_command_ff[CMD_W-1];
               cmag1_in = (cmd_abs > CMD_MAX) ? CMD_MAX : cmd_abs[CMAG_W-1:0];
            end
         end
         MODE_TEST: begin
            // square wave in quarters: +, -, +, -; last tick reuses the level
            if (!last_tick) begin
               if ((quad >= Q1_BOUND && quad < Q2_BOUND) || quad >= Q3_BOUND) begin
                  test_level_in = -TEST_AMPL;
               end else begin
                  test_level_in = TEST_AMPL;
               end
               test_counter_in = test_counter_ff + 1'b1;
            end else begin
               test_counter_in = '0;
               test_done       = 1'b1;
            end
            pi_run        = 1'b1;
            pi_ref        = CUR_W'(test_level_in);
            meta1_in.kind = KIND_PI;
            meta1_in.tref = test_level_in;
            meta1_in.tidx = IDX_W'(test_counter_ff);
            meta1_in.tact = !last_tick;
         end
         MODE_HOLD, MODE_TRACK: begin
            pi_run        = 1'b1;
            meta1_in.kind = KIND_PI;
         end
         default: begin
            meta1_in.kind = KIND_HOLD;
         end
      endcase

      // error and clamped integrator
      err1_in = ERR_W'(pi_ref) - ERR_W'(meas);
      acc_raw = ACC_W'(integrator_ff) + ACC_W'(err1_in);
      lim_pos = $signed({{(ACC_W-LIM_W){1'b0}}, integ_limit_ff});
      if (acc_raw > lim_pos) begin
         acc_sat = INT_W'(lim_pos);
      end else if (acc_raw < -lim_pos) begin
         acc_sat = INT_W'(-lim_pos);
      end else begin
         acc_sat = INT_W'(acc_raw);
      end

      integrator_in = integrator_ff;
      if (test_done) begin
         integrator_in = '0;       // test run over: clear for the next run
      end else if (pi_run) begin
         integrator_in = acc_sat;
      end
   end

   // ---------------- stage 2: gain products ----------------
   always_comb begin
      pprop2_in = $signed({1'b0, prop_gain_ff}) * err1_ff;
      pint2_in  = $signed({1'b0, integ_gain_ff}) * acc1_ff;
   end

   // ---------------- stage 3: sum, clamp to 100 percent, sign ----------------
   logic signed [U_W-1:0] u_sum, u_sat;

   always_comb begin
      u_sum = U_W'(pprop2_ff) + U_W'(pint2_ff);
      if (u_sum > U_W'(FULL_SCALE_Q12)) begin
         u_sat = U_W'(FULL_SCALE_Q12);
      end else if (u_sum < -U_W'(FULL_SCALE_Q12)) begin
         u_sat = -U_W'(FULL_SCALE_Q12);
      end else begin
         u_sat = u_sum;
      end
      meta3_in = meta2_ff;
      if (meta2_ff.kind == KIND_PI) begin
         meta3_in.dir      = (u_sat > 0);
         meta3_in.keep_dir = (u_sat == 0);
         mag3_in = u_sat[U_W-1] ? MAG_W'(-u_sat) : MAG_W'(u_sat);
      end else begin
         mag3_in = MAG_W'(cmag2_ff);
      end
   end

   // ---------------- stage 4: scale to PWM counts ----------------
   always_comb begin
      if (meta3_ff.kind == KIND_PI) begin
         prod4_in = PROD_W'(mag3_ff) * PROD_W'(PERIOD_PI);
      end else begin
         prod4_in = PROD_W'(mag3_ff) * PROD_W'(PERIOD_PWM);
      end
   end

   // ---------------- stage 5: divide by 100 via reciprocal ----------------
   logic [NUM_W-1:0] num5;

   always_comb begin
      if (meta4_ff.kind == KIND_PI) begin
         num5 = NUM_W'(prod4_ff >> Q12_SHIFT);
      end else begin
         num5 = NUM_W'(prod4_ff);
      end
      qp5_in = QP_W'(num5) * QP_W'(DIV_RECIP);
   end

   // ---------------- result stage: saturate and resolve held values ----------------
   logic [QV_W-1:0]   qv;
   logic [DUTY_W-1:0] duty_calc;

   always_comb begin
      qv        = qp5_ff[QP_W-1:DIV_SHIFT];
      duty_calc = (qv > QV_W'(DUTY_MAX)) ? DUTY_MAX : qv[DUTY_W-1:0];
      case (meta5_ff.kind)
         KIND_ZERO: begin
            duty_out_in = '0;
            dir_out_in  = 1'b0;
         end
         KIND_PWM: begin
            duty_out_in = duty_calc;
            dir_out_in  = meta5_ff.dir;
         end
         KIND_PI: begin
            duty_out_in = duty_calc;
            dir_out_in  = meta5_ff.keep_dir ? dir_held_ff : meta5_ff.dir;
         end
         default: begin
            duty_out_in = duty_held_ff;
            dir_out_in  = dir_held_ff;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         pwm_command_ff  <= '0;
         prop_gain_ff    <= GAIN_W'(410);
         integ_gain_ff   <= GAIN_W'(164);
         integ_limit_ff  <= LIM_W'(99975);
         integrator_ff   <= '0;
         test_counter_ff <= '0;
         test_level_ff   <= '0;
         duty_held_ff    <= '0;
         dir_held_ff     <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         v3_ff           <= 1'b0;
         v4_ff           <= 1'b0;
         v5_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // the user must make csr writes only with the pipeline empty, unchecked here; a test run drops to idle itself
         if (csr_we) begin
            case (csr_index)
               REG_MODE:        mode_ff        <= csr_wdata[2:0];
               REG_PWM_COMMAND: pwm_command_ff <= csr_wdata[CMD_W-1:0];
               REG_PROP_GAIN:   prop_gain_ff   <= csr_wdata[GAIN_W-1:0];
               REG_INTEG_GAIN:  integ_gain_ff  <= csr_wdata[GAIN_W-1:0];
               REG_INTEG_LIMIT: integ_limit_ff <= csr_wdata[LIM_W-1:0];
               default: ;
            endcase
         end else if (req_take && test_done) begin
            mode_ff <= MODE_IDLE;
         end

         if (req_take) begin
            integrator_ff   <= integrator_in;
            test_counter_ff <= test_counter_in;
            test_level_ff   <= test_level_in;
         end
         if (rdy6 && v5_ff) begin
            duty_held_ff <= duty_out_in;
            dir_held_ff  <= dir_out_in;
         end

         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) rsp_valid_ff <= v5_ff;
      end
   end

   // payload stages, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         meta1_ff <= meta1_in;
         cmag1_ff <= cmag1_in;
         err1_ff  <= err1_in;
         acc1_ff  <= acc_sat;
      end
      if (rdy2 && v1_ff) begin
         meta2_ff  <= meta1_ff;
         cmag2_ff  <= cmag1_ff;
         pprop2_ff <= pprop2_in;
         pint2_ff  <= pint2_in;
      end
      if (rdy3 && v2_ff) begin
         meta3_ff <= meta3_in;
         mag3_ff  <= mag3_in;
      end
      if (rdy4 && v3_ff) begin
         meta4_ff <= meta3_ff;
         prod4_ff <= prod4_in;
      end
      if (rdy5 && v4_ff) begin
         meta5_ff <= meta4_ff;
         qp5_ff   <= qp5_in;
      end
      if (rdy6 && v5_ff) begin
         meta_out_ff <= meta5_ff;
         duty_out_ff <= duty_out_in;
         dir_out_ff  <= dir_out_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, meta_out_ff.tact, meta_out_ff.tidx, meta_out_ff.tref,
                        dir_out_ff, duty_out_ff};

   // ---------------- assertions ----------------
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      test_counter_ff <= CNT_LAST)
      else $error("test counter beyond run length");

   a_test_end: assert property (@(posedge clock) disable iff (reset)
      req_take && test_done && !csr_we |=>
         mode_ff == MODE_IDLE && integrator_ff == '0 && test_counter_ff == '0)
      else $error("test run did not end cleanly");

   a_test_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[29] |->
         $signed(rsp_tdata[21:13]) == TEST_AMPL || $signed(rsp_tdata[21:13]) == -TEST_AMPL)
      else $error("active test beat without square-wave level");

endmodule
